[sv/y2r_pkg.sv]
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared widths, register indexes, reset values and stage types for the
// YUYV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

    localparam int unsigned PIX_W      = 8;   // one sample or one colour channel
    localparam int unsigned COEF_W     = 10;  // gain and chroma coefficients
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned IN_W       = 32;  // Y0, U, Y1, V
    localparam int unsigned OUT_W      = 80;  // two pixels of R, G, B, RGB565
    localparam int unsigned DIFF_W     = 9;   // luma minus offset, signed
    localparam int unsigned CHR_W      = 8;   // chroma minus bias, signed
    localparam int unsigned YPROD_W    = 20;  // gain * luma difference
    localparam int unsigned CPROD_W    = 19;  // coefficient * chroma difference
    localparam int unsigned SUM_W      = 20;  // channel sum before the shift
    localparam int unsigned RGB565_W   = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_FROM_V   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FROM_U = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_FROM_V = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FROM_U  = 3'd5;

    // Reset values
    localparam logic [PIX_W-1:0]  RST_LUMA_OFFSET  = 8'd0;
    localparam logic [COEF_W-1:0] RST_LUMA_GAIN    = 10'd298;
    localparam logic [COEF_W-1:0] RST_RED_FROM_V   = 10'd400;
    localparam logic [COEF_W-1:0] RST_GREEN_FROM_U = 10'd100;
    localparam logic [COEF_W-1:0] RST_GREEN_FROM_V = 10'd208;
    localparam logic [COEF_W-1:0] RST_BLUE_FROM_U  = 10'd516;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = 20'sd128;

    typedef struct packed {
        logic [PIX_W-1:0]  luma_offset;
        logic [COEF_W-1:0] luma_gain;
        logic [COEF_W-1:0] red_from_v;
        logic [COEF_W-1:0] green_from_u;
        logic [COEF_W-1:0] green_from_v;
        logic [COEF_W-1:0] blue_from_u;
    } t_cfg;

    typedef struct packed {
        logic signed [DIFF_W-1:0] y0;
        logic signed [DIFF_W-1:0] y1;
        logic signed [CHR_W-1:0]  u;
        logic signed [CHR_W-1:0]  v;
    } t_diff;

    typedef struct packed {
        logic signed [YPROD_W-1:0] ys0;
        logic signed [YPROD_W-1:0] ys1;
        logic signed [CPROD_W-1:0] rv;
        logic signed [CPROD_W-1:0] gu;
        logic signed [CPROD_W-1:0] gv;
        logic signed [CPROD_W-1:0] bu;
    } t_prod;

    typedef struct packed {
        logic signed [SUM_W-1:0] r0;
        logic signed [SUM_W-1:0] g0;
        logic signed [SUM_W-1:0] b0;
        logic signed [SUM_W-1:0] r1;
        logic signed [SUM_W-1:0] g1;
        logic signed [SUM_W-1:0] b1;
    } t_sums;

endpackage

`default_nettype wire

[sv/y2r_mult.sv]
// ----------------------------------------------------------------------------
// y2r_mult
// Bias removal stage followed by the coefficient multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_mult (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire y2r_pkg::t_cfg         i_cfg,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire [y2r_pkg::IN_W-1:0]    i_data,
    output logic                       o_valid,
    input  wire                        i_ready,
    output y2r_pkg::t_prod             o_prod
);

    logic           r_v1;
    logic           r_v2;
    y2r_pkg::t_diff r_diff;
    y2r_pkg::t_diff n_diff;
    y2r_pkg::t_prod r_prod;
    y2r_pkg::t_prod n_prod;
    logic           en1;
    logic           en2;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_prod  = r_prod;

    // Remove luma offset and chroma bias (U - 128 is U with its top bit flipped)
    always_comb begin
        n_diff.y0 = $signed({1'b0, i_data[7:0]})   - $signed({1'b0, i_cfg.luma_offset});
        n_diff.y1 = $signed({1'b0, i_data[23:16]}) - $signed({1'b0, i_cfg.luma_offset});
        n_diff.u  = $signed({~i_data[15], i_data[14:8]});
        n_diff.v  = $signed({~i_data[31], i_data[30:24]});
    end

    always_comb begin
        n_prod.ys0 = y2r_pkg::YPROD_W'($signed({1'b0, i_cfg.luma_gain}))
                     * y2r_pkg::YPROD_W'(r_diff.y0);
        n_prod.ys1 = y2r_pkg::YPROD_W'($signed({1'b0, i_cfg.luma_gain}))
                     * y2r_pkg::YPROD_W'(r_diff.y1);
        n_prod.rv  = y2r_pkg::CPROD_W'($signed({1'b0, i_cfg.red_from_v}))
                     * y2r_pkg::CPROD_W'(r_diff.v);
        n_prod.gu  = y2r_pkg::CPROD_W'($signed({1'b0, i_cfg.green_from_u}))
                     * y2r_pkg::CPROD_W'(r_diff.u);
        n_prod.gv  = y2r_pkg::CPROD_W'($signed({1'b0, i_cfg.green_from_v}))
                     * y2r_pkg::CPROD_W'(r_diff.v);
        n_prod.bu  = y2r_pkg::CPROD_W'($signed({1'b0, i_cfg.blue_from_u}))
                     * y2r_pkg::CPROD_W'(r_diff.u);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_diff <= n_diff;
        end
        if (en2 && r_v1) begin
            r_prod <= n_prod;
        end
    end

endmodule

`default_nettype wire

[sv/y2r_sum.sv]
// ----------------------------------------------------------------------------
// y2r_sum
// Channel sum stage: luma term plus or minus chroma terms plus rounding half.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_sum (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire y2r_pkg::t_prod i_prod,
    output logic            o_valid,
    input  wire             i_ready,
    output y2r_pkg::t_sums  o_sums
);

    logic           r_valid;
    y2r_pkg::t_sums r_sums;
    y2r_pkg::t_sums n_sums;
    logic           en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_sums  = r_sums;

    always_comb begin
        n_sums.r0 = i_prod.ys0 + y2r_pkg::SUM_W'(i_prod.rv) + y2r_pkg::ROUND_HALF;
        n_sums.g0 = i_prod.ys0 - y2r_pkg::SUM_W'(i_prod.gu) - y2r_pkg::SUM_W'(i_prod.gv)
                    + y2r_pkg::ROUND_HALF;
        n_sums.b0 = i_prod.ys0 + y2r_pkg::SUM_W'(i_prod.bu) + y2r_pkg::ROUND_HALF;
        n_sums.r1 = i_prod.ys1 + y2r_pkg::SUM_W'(i_prod.rv) + y2r_pkg::ROUND_HALF;
        n_sums.g1 = i_prod.ys1 - y2r_pkg::SUM_W'(i_prod.gu) - y2r_pkg::SUM_W'(i_prod.gv)
                    + y2r_pkg::ROUND_HALF;
        n_sums.b1 = i_prod.ys1 + y2r_pkg::SUM_W'(i_prod.bu) + y2r_pkg::ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_sums <= n_sums;
        end
    end

endmodule

`default_nettype wire

[sv/y2r_pack.sv]
// ----------------------------------------------------------------------------
// y2r_pack
// Shift, saturate to 0..255 and pack RGB565; holds the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_pack (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire y2r_pkg::t_sums       i_sums,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [y2r_pkg::OUT_W-1:0] o_data
);

    // Floor shift by 8, clamp negative to 0 and overflow to 255
    function automatic logic [y2r_pkg::PIX_W-1:0] sat8(
        input logic signed [y2r_pkg::SUM_W-1:0] s
    );
        logic [y2r_pkg::PIX_W-1:0] res;
        if (s[y2r_pkg::SUM_W-1]) begin
            res = '0;
        end else if (|s[y2r_pkg::SUM_W-2:16]) begin
            res = '1;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    function automatic logic [y2r_pkg::RGB565_W-1:0] rgb565(
        input logic [y2r_pkg::PIX_W-1:0] r,
        input logic [y2r_pkg::PIX_W-1:0] g,
        input logic [y2r_pkg::PIX_W-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    logic                      r_valid;
    logic [y2r_pkg::OUT_W-1:0] r_data;
    logic [y2r_pkg::OUT_W-1:0] n_data;
    logic [y2r_pkg::PIX_W-1:0] r0, g0, b0, r1, g1, b1;
    logic                      en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        r0 = sat8(i_sums.r0);
        g0 = sat8(i_sums.g0);
        b0 = sat8(i_sums.b0);
        r1 = sat8(i_sums.r1);
        g1 = sat8(i_sums.g1);
        b1 = sat8(i_sums.b1);
        n_data = {rgb565(r1, g1, b1), b1, g1, r1, rgb565(r0, g0, b0), b0, g0, r0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

[sv/yuyv_to_rgb_converter_core.sv]
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_core
// YUYV 4:2:2 macro-pixel in, two RGB888 pixels plus their RGB565 words out.
// ----------------------------------------------------------------------------
// One beat on the slave side carries a macro-pixel (Y0, U, Y1, V); one beat on
// the master side carries both converted pixels. The block takes one beat per
// clock unless a stall on m_axis_tready has filled every stage, and passes
// each beat through offset removal, coefficient multiply, channel sum, and
// saturate/pack into the output register on its way to the master side. Each
// stage holds only while it is full and the stage after it cannot take its beat,
// so bubbles collapse and a stall on m_axis_tready reaches s_axis_tready in the
// same cycle only once every stage is full. Coefficients come from six registers
// written through the plain write port; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_rgb_converter_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Configuration write port
    input  wire                             i_cfg_we,
    input  wire [y2r_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [y2r_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Slave side
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
    input  wire [y2r_pkg::IN_W-1:0]         s_axis_tdata,
    // Master side
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // red_first[7:0], green_first[15:8], blue_first[23:16], packed_first[39:24],
    // red_second[47:40], green_second[55:48], blue_second[63:56],
    // packed_second[79:64]
    output logic [y2r_pkg::OUT_W-1:0]       m_axis_tdata
);

    y2r_pkg::t_cfg  r_cfg;
    y2r_pkg::t_prod prod;
    y2r_pkg::t_sums sums;
    logic           prod_valid;
    logic           sum_ready;
    logic           sum_valid;
    logic           pack_ready;

    // Coefficient registers: keep only each register's low bits, drop writes
    // to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_offset  <= y2r_pkg::RST_LUMA_OFFSET;
            r_cfg.luma_gain    <= y2r_pkg::RST_LUMA_GAIN;
            r_cfg.red_from_v   <= y2r_pkg::RST_RED_FROM_V;
            r_cfg.green_from_u <= y2r_pkg::RST_GREEN_FROM_U;
            r_cfg.green_from_v <= y2r_pkg::RST_GREEN_FROM_V;
            r_cfg.blue_from_u  <= y2r_pkg::RST_BLUE_FROM_U;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                y2r_pkg::CFG_LUMA_OFFSET: begin
                    r_cfg.luma_offset <= i_cfg_data[y2r_pkg::PIX_W-1:0];
                end
                y2r_pkg::CFG_LUMA_GAIN:    r_cfg.luma_gain    <= i_cfg_data;
                y2r_pkg::CFG_RED_FROM_V:   r_cfg.red_from_v   <= i_cfg_data;
                y2r_pkg::CFG_GREEN_FROM_U: r_cfg.green_from_u <= i_cfg_data;
                y2r_pkg::CFG_GREEN_FROM_V: r_cfg.green_from_v <= i_cfg_data;
                y2r_pkg::CFG_BLUE_FROM_U:  r_cfg.blue_from_u  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stages one and two: offset removal, then the six products
    y2r_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (prod_valid),
        .i_ready (sum_ready),
        .o_prod  (prod)
    );

    // Stage three: channel sums with rounding
    y2r_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (sum_ready),
        .i_prod  (prod),
        .o_valid (sum_valid),
        .i_ready (pack_ready),
        .o_sums  (sums)
    );

    // Stage four: saturate, pack and hold the output beat
    y2r_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (pack_ready),
        .i_sums  (sums),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[sv/y2r_checker.sv]
// ----------------------------------------------------------------------------
// y2r_checker
// Port-level checks on the converter's stream behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [y2r_pkg::OUT_W-1:0]        m_axis_tdata
);

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // A waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    // Input back-pressure only when the output is blocked
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with output free");

    // A result appearing on an empty output came from an input beat accepted earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
        else $error("output beat without matching input beat");

endmodule

bind yuyv_to_rgb_converter_core y2r_checker u_y2r_checker (.*);

`default_nettype wire
